// ===== sv/ffpa_pkg.sv =====
// package: types, constants and codes for the first-fit page range allocator
package ffpa_pkg;

    localparam int MAX_REGIONS_DEF      = 64;
    localparam int PAGE_NUMBER_BITS_DEF = 20;

    localparam int FUNC_W   = 2;
    localparam int START_W  = PAGE_NUMBER_BITS_DEF;
    localparam int COUNT_W  = PAGE_NUMBER_BITS_DEF + 1;
    localparam int STATUS_W = 2;

    localparam logic [FUNC_W-1:0] FN_ALLOC = 2'd0;
    localparam logic [FUNC_W-1:0] FN_FREE  = 2'd1;
    localparam logic [FUNC_W-1:0] FN_INIT  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOFIT   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    localparam logic CFG_HEAP_START = 1'b0;
    localparam logic CFG_HEAP_COUNT = 1'b1;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [START_W-1:0] start_page;
        logic [COUNT_W-1:0] page_count;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [START_W-1:0]  alloc_page;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_DONE
    } t_state;

    // cell update commands
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_SHIFT_DOWN,
        OP_SHIFT_UP,
        OP_LOAD,
        OP_LOAD_DROP,
        OP_CLEAR,
        OP_INIT
    } t_op;

    typedef struct packed {
        t_op op;
        logic [10:0] target;
    } t_cmd;

endpackage

// ===== sv/first_fit_page_range_allocator.sv =====
// top level: first-fit page range allocator, a controller over a chain of range cells
// Usage:
// - input channel i_valid / o_stall carries one request item: func, start_page,
//   page_count. func alloc takes the first free range long enough, free returns a
//   range and merges it with touching neighbors, init loads the heap from config.
// - output channel o_valid / i_stall carries one result item per request:
//   status and alloc_page.
// - config port i_cfg_we / i_cfg_index / i_cfg_data sets heap_start_page (0) and
//   heap_page_count (1); write only while idle.
// - after the accepting edge, in the EVAL state every cell compares in
//   parallel and a priority pick drives the shift/load of the cell chain; the
//   result register is loaded at the end of EVAL and o_valid is raised in the
//   DONE state, where the result is taken at an edge with i_stall low.
// - one request at a time: a new item is accepted the cycle after the result
//   is taken, never while a request is still in flight.
// - while the receiver stalls the result holds and no new item is taken.
// - synchronous reset empties the table (all cell valid bits cleared) and
//   zeroes both config registers; no clearing pass is needed.
module first_fit_page_range_allocator
    import ffpa_pkg::*;
#(
    parameter int MAX_REGIONS = MAX_REGIONS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [COUNT_W-1:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in_item    i_item,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out_item   o_item
);

    localparam int MR = MAX_REGIONS;
    localparam int PB = PAGE_NUMBER_BITS_DEF;
    localparam int IW = $clog2(MR);

    logic [MR-1:0] cv;
    logic [MR*PB-1:0] cs;
    logic [MR*(PB+1)-1:0] cl;
    t_cmd cmd;
    logic [PB-1:0] ld_s;
    logic [PB:0] ld_l;

    ffpa_ctrl #(.MR(MR), .PB(PB), .IW(IW)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_stall(o_stall), .i_item(i_item),
        .o_valid(o_valid), .i_stall(i_stall), .o_item(o_item),
        .i_cv(cv), .i_cs(cs), .i_cl(cl),
        .o_cmd(cmd), .o_load_start(ld_s), .o_load_len(ld_l)
    );

    for (genvar g = 0; g < MR; g++) begin : g_cell
        logic pv, nv;
        logic [PB-1:0] psv, nsv;
        logic [PB:0] plv, nlv;
        if (g == 0) begin : g_lo
            assign pv = 1'b0;
            assign psv = '0;
            assign plv = '0;
        end else begin : g_mid
            assign pv = cv[g-1];
            assign psv = cs[(g-1)*PB +: PB];
            assign plv = cl[(g-1)*(PB+1) +: PB+1];
        end
        if (g == MR - 1) begin : g_hi
            assign nv = 1'b0;
            assign nsv = '0;
            assign nlv = '0;
        end else begin : g_top
            assign nv = cv[g+1];
            assign nsv = cs[(g+1)*PB +: PB];
            assign nlv = cl[(g+1)*(PB+1) +: PB+1];
        end
        ffpa_cell #(.PB(PB), .IW(IW)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_index(IW'(g)), .i_cmd(cmd),
            .i_load_start(ld_s), .i_load_len(ld_l),
            .i_prev_valid(pv), .i_prev_start(psv), .i_prev_len(plv),
            .i_next_valid(nv), .i_next_start(nsv), .i_next_len(nlv),
            .o_valid(cv[g]), .o_start(cs[g*PB +: PB]),
            .o_len(cl[g*(PB+1) +: PB+1])
        );
    end

endmodule

// ===== sv/ffpa_cell.sv =====
// one table cell: holds one free range and its valid bit
module ffpa_cell
    import ffpa_pkg::*;
#(
    parameter int PB = PAGE_NUMBER_BITS_DEF,
    parameter int IW = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [IW-1:0] i_index,
    input  t_cmd          i_cmd,
    input  logic [PB-1:0] i_load_start,
    input  logic [PB:0]   i_load_len,
    input  logic          i_prev_valid,
    input  logic [PB-1:0] i_prev_start,
    input  logic [PB:0]   i_prev_len,
    input  logic          i_next_valid,
    input  logic [PB-1:0] i_next_start,
    input  logic [PB:0]   i_next_len,
    output logic          o_valid,
    output logic [PB-1:0] o_start,
    output logic [PB:0]   o_len
);

    logic          r_valid, n_valid;
    logic [PB-1:0] r_start, n_start;
    logic [PB:0]   r_len, n_len;
    logic          at, above, atabove;

    assign at      = (i_cmd.target[IW-1:0] == i_index);
    assign above   = (i_index > i_cmd.target[IW-1:0]);
    assign atabove = at || above;

    always_comb begin
        n_valid = r_valid;
        n_start = r_start;
        n_len   = r_len;
        unique case (i_cmd.op)
            OP_HOLD: ;
            OP_CLEAR: n_valid = 1'b0;
            OP_LOAD: begin
                if (at) begin
                    n_valid = 1'b1;
                    n_start = i_load_start;
                    n_len   = i_load_len;
                end
            end
            OP_SHIFT_UP: begin
                if (at) begin
                    n_valid = 1'b1;
                    n_start = i_load_start;
                    n_len   = i_load_len;
                end else if (above) begin
                    n_valid = i_prev_valid;
                    n_start = i_prev_start;
                    n_len   = i_prev_len;
                end
            end
            OP_SHIFT_DOWN: begin
                if (atabove) begin
                    n_valid = i_next_valid;
                    n_start = i_next_start;
                    n_len   = i_next_len;
                end
            end
            OP_LOAD_DROP: begin
                // load this cell, then close the gap above it
                if (at) begin
                    n_start = i_load_start;
                    n_len   = i_load_len;
                end else if (above) begin
                    n_valid = i_next_valid;
                    n_start = i_next_start;
                    n_len   = i_next_len;
                end
            end
            OP_INIT: begin
                // load this cell, empty everything above it
                if (at) begin
                    n_valid = 1'b1;
                    n_start = i_load_start;
                    n_len   = i_load_len;
                end else if (above) begin
                    n_valid = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_start <= n_start;
        r_len   <= n_len;
    end

    assign o_valid = r_valid;
    assign o_start = r_start;
    assign o_len   = r_len;

endmodule

// ===== sv/ffpa_ctrl.sv =====
// controller: scans cell flags, picks the first hit and issues the table update
module ffpa_ctrl
    import ffpa_pkg::*;
#(
    parameter int MR = MAX_REGIONS_DEF,
    parameter int PB = PAGE_NUMBER_BITS_DEF,
    parameter int IW = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_index,
    input  logic [COUNT_W-1:0] i_cfg_data,
    input  logic          i_valid,
    output logic          o_stall,
    input  t_in_item      i_item,
    output logic          o_valid,
    input  logic          i_stall,
    output t_out_item     o_item,
    input  logic [MR-1:0] i_cv,
    input  logic [MR*PB-1:0]     i_cs,
    input  logic [MR*(PB+1)-1:0] i_cl,
    output t_cmd          o_cmd,
    output logic [PB-1:0] o_load_start,
    output logic [PB:0]   o_load_len
);

    localparam logic [PB+1:0] SPACE = {2'b01, {PB{1'b0}}};

    t_state r_state, n_state;
    t_in_item r_req;
    logic [START_W-1:0] r_hs;
    logic [COUNT_W-1:0] r_hc;
    logic r_ov;
    t_out_item r_out;

    logic [MR-1:0] fit, lt;
    logic [IW:0] fit_idx, p_idx;
    logic fit_any;
    logic [PB-1:0] s;
    logic [PB:0] n;

    assign s = PB'(r_req.start_page);
    assign n = (PB+1)'(r_req.page_count);

    always_comb begin
        for (int i = 0; i < MR; i++) begin
            fit[i] = i_cv[i] && ({1'b0, i_cl[i*(PB+1) +: PB+1]} >= {1'b0, n});
            lt[i]  = i_cv[i] && (i_cs[i*PB +: PB] < s);
        end
    end

    // priority pick over cells; the lowest-index hit wins
    always_comb begin
        fit_idx = (IW+1)'(MR);
        fit_any = 1'b0;
        for (int i = MR - 1; i >= 0; i--) begin
            if (fit[i]) begin
                fit_idx = (IW+1)'(i);
                fit_any = 1'b1;
            end
        end
        // first cell that is empty or does not start below the range
        p_idx = (IW+1)'(MR);
        for (int i = MR - 1; i >= 0; i--) begin
            if (!lt[i]) p_idx = (IW+1)'(i);
        end
    end

    logic [IW:0] used;
    always_comb begin
        used = '0;
        for (int i = 0; i < MR; i++) begin
            if (i_cv[i]) used = (IW+1)'(i + 1);
        end
    end

    logic [IW-1:0] fi, pi, pm;
    logic [PB-1:0] fs, ps, xs;
    logic [PB:0] fl, pl, xl;
    logic has_prev, has_next, back, fwd_b, fwd;
    logic [PB+2:0] prev_end, sum1, sum2, nend;
    logic [PB:0] sat1, sat2, satx;

    always_comb begin
        fi = fit_idx[IW-1:0];
        pi = p_idx[IW-1:0];
        pm = IW'(p_idx - 1'b1);
        fs = i_cs[fi*PB +: PB];
        fl = i_cl[fi*(PB+1) +: PB+1];
        ps = i_cs[pm*PB +: PB];
        pl = i_cl[pm*(PB+1) +: PB+1];
        xs = i_cs[pi*PB +: PB];
        xl = i_cl[pi*(PB+1) +: PB+1];
        has_prev = (p_idx != '0);
        has_next = (p_idx < used);
        prev_end = (PB+3)'(ps) + (PB+3)'(pl);
        back = has_prev && (prev_end == (PB+3)'(s));
        nend = (PB+3)'(s) + (PB+3)'(n);
        fwd_b = has_next && (prev_end + (PB+3)'(n) == (PB+3)'(xs));
        fwd = has_next && (nend == (PB+3)'(xs));
        sum1 = (PB+3)'(pl) + (PB+3)'(n);
        sat1 = (sum1 > (PB+3)'(SPACE)) ? SPACE[PB:0] : sum1[PB:0];
        sum2 = (PB+3)'(sat1) + (PB+3)'(xl);
        sat2 = (sum2 > (PB+3)'(SPACE)) ? SPACE[PB:0] : sum2[PB:0];
        satx = ((PB+3)'(xl) + (PB+3)'(n) > (PB+3)'(SPACE)) ? SPACE[PB:0]
             : PB'(0) + xl + n;
    end

    logic [PB+1:0] room;
    logic [PB:0] ilen;
    always_comb begin
        room = ({2'b0, PB'(r_hs)} < SPACE) ? SPACE - (PB+2)'(r_hs) : '0;
        ilen = ((PB+2)'(r_hc) > room) ? room[PB:0] : (PB+1)'(r_hc);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_valid) n_state = S_EVAL;
            S_EVAL:  n_state = S_DONE;
            S_DONE:  if (!i_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    t_out_item res;
    always_comb begin
        o_cmd.op = OP_HOLD;
        o_cmd.target = '0;
        o_load_start = s;
        o_load_len = n;
        res.status = ST_OK;
        res.alloc_page = '0;
        if (r_state == S_EVAL) begin
            unique case (r_req.func)
                FN_ALLOC: begin
                    if (n == '0) begin
                        res.status = ST_IGNORED;
                    end else if (!fit_any) begin
                        res.status = ST_NOFIT;
                    end else begin
                        res.alloc_page = START_W'(fs);
                        o_cmd.target = 11'(fi);
                        if (fl == n) begin
                            o_cmd.op = OP_SHIFT_DOWN;
                        end else begin
                            o_cmd.op = OP_LOAD;
                            o_load_start = fs + n[PB-1:0];
                            o_load_len = fl - n;
                        end
                    end
                end
                FN_FREE: begin
                    if (s == '0 || n == '0 || r_ov) begin
                        res.status = ST_IGNORED;
                    end else if (back) begin
                        o_cmd.target = 11'(pm);
                        o_load_start = ps;
                        if (fwd_b) begin
                            o_cmd.op = OP_LOAD_DROP;
                            o_load_len = sat2;
                        end else begin
                            o_cmd.op = OP_LOAD;
                            o_load_len = sat1;
                        end
                    end else if (fwd) begin
                        o_cmd.op = OP_LOAD;
                        o_cmd.target = 11'(pi);
                        o_load_len = satx;
                    end else if (used == (IW+1)'(MR)) begin
                        res.status = ST_FULL;
                    end else begin
                        o_cmd.op = OP_SHIFT_UP;
                        o_cmd.target = 11'(pi);
                    end
                end
                FN_INIT: begin
                    o_cmd.op = (ilen == '0) ? OP_CLEAR : OP_INIT;
                    o_cmd.target = '0;
                    o_load_start = PB'(r_hs);
                    o_load_len = ilen;
                end
                default: res.status = ST_IGNORED;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_hs <= '0;
            r_hc <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_HEAP_START) r_hs <= i_cfg_data[START_W-1:0];
                else r_hc <= i_cfg_data;
            end
        end
        if (r_state == S_IDLE && i_valid) begin
            r_req <= i_item;
            r_ov <= ((PB+2)'(i_item.start_page) + (PB+2)'(i_item.page_count)) > SPACE;
        end
        if (r_state == S_EVAL) r_out <= res;
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_DONE);
    assign o_item  = r_out;

endmodule
